/* sv/tvg_pkg.sv */
package tvg_pkg;

    // Field and datapath widths
    localparam int INDEX_W        = 10;
    localparam int COUNT_W        = 11;
    localparam int RADIUS_W       = 16;
    localparam int ANGLE_BITS     = 16;
    localparam int MAX_RESOLUTION = 1024;
    localparam int CORDIC_STEPS   = 24;
    localparam int XY_W           = 34;
    localparam int Z_W            = 33;
    localparam int TRIG_W         = 32;
    localparam int POS_W          = 32;
    localparam int NORM_W         = 16;
    localparam int REM_W          = ANGLE_BITS - 2;
    localparam int TWO_PI_W       = 33;
    localparam int PROD_W         = REM_W + TWO_PI_W;

    localparam logic [XY_W-1:0]     CORDIC_GAIN_Q30 = XY_W'(652032874);
    localparam logic [TWO_PI_W-1:0] TWO_PI_Q30      = 33'd6746518852;

    // Configuration register indexes
    localparam logic [1:0] CFG_CENTRE_RADIUS = 2'd0;
    localparam logic [1:0] CFG_TUBE_RADIUS   = 2'd1;
    localparam logic [1:0] CFG_SEGMENT_COUNT = 2'd2;
    localparam logic [1:0] CFG_RING_COUNT    = 2'd3;

    typedef struct packed {
        logic                  valid;
        logic                  err;
        logic [COUNT_W-1:0]    ring_rem;
        logic [ANGLE_BITS-1:0] ring_q;
        logic [COUNT_W-1:0]    seg_rem;
        logic [ANGLE_BITS-1:0] seg_q;
    } div_stage_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             quad;
    } cordic_lane_t;

    typedef struct packed {
        logic         valid;
        logic         err;
        cordic_lane_t ring;
        cordic_lane_t seg;
    } cordic_stage_t;

    typedef struct packed {
        logic                     valid;
        logic                     err;
        logic signed [TRIG_W-1:0] cp;
        logic signed [TRIG_W-1:0] sp;
        logic signed [TRIG_W-1:0] ct;
        logic signed [TRIG_W-1:0] st;
    } trig_stage_t;

    typedef struct packed {
        logic                     valid;
        logic                     err;
        logic signed [48:0]       ring38;
        logic signed [48:0]       tp;
        logic signed [63:0]       cpct;
        logic signed [63:0]       cpst;
        logic signed [NORM_W-1:0] ny;
        logic signed [TRIG_W-1:0] ct;
        logic signed [TRIG_W-1:0] st;
    } mul1_stage_t;

    typedef struct packed {
        logic                     valid;
        logic                     err;
        logic signed [26:0]       ring16;
        logic signed [TRIG_W-1:0] ct;
        logic signed [TRIG_W-1:0] st;
        logic signed [POS_W-1:0]  py;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
    } mul2_stage_t;

    typedef struct packed {
        logic                     valid;
        logic                     err;
        logic signed [58:0]       pxp;
        logic signed [58:0]       pzp;
        logic signed [POS_W-1:0]  py;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
    } mul3_stage_t;

    typedef struct packed {
        logic                     valid;
        logic                     err;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
    } result_t;

    // Arctangent of 2^-i in Q30
    function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            0:  a = Z_W'(843314856);
            1:  a = Z_W'(497837829);
            2:  a = Z_W'(263043836);
            3:  a = Z_W'(133525158);
            4:  a = Z_W'(67021686);
            5:  a = Z_W'(33543515);
            6:  a = Z_W'(16775850);
            7:  a = Z_W'(8388437);
            8:  a = Z_W'(4194282);
            9:  a = Z_W'(2097149);
            10: a = Z_W'(1048575);
            11: a = Z_W'(524287);
            12: a = Z_W'(262143);
            13: a = Z_W'(131071);
            14: a = Z_W'(65535);
            15: a = Z_W'(32767);
            16: a = Z_W'(16383);
            17: a = Z_W'(8191);
            18: a = Z_W'(4095);
            19: a = Z_W'(2047);
            20: a = Z_W'(1023);
            21: a = Z_W'(511);
            22: a = Z_W'(255);
            23: a = Z_W'(127);
            default: a = '0;
        endcase
        return a;
    endfunction

    // Limit a rounded normal component to plus or minus one
    function automatic logic signed [NORM_W-1:0] clamp_unit(input logic signed [19:0] v);
        logic signed [NORM_W-1:0] r;
        if (v > 20'sd16384)
            r = 16'sd16384;
        else if (v < -20'sd16384)
            r = -16'sd16384;
        else
            r = v[NORM_W-1:0];
        return r;
    endfunction

endpackage

/* sv/torus_vertex_generator.sv */
// Throughput: one word per cycle while the skid entry is empty, set by the 16-stage phase
// divider and the 24-stage CORDIC pipeline, each stage taking a new word every cycle
// unless the pipeline stalls.
// A two-entry output register with skid keeps the input side open while a result waits.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the radii and
// counts with 512, 256, 32 and 32.
module torus_vertex_generator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // ring_index[9:0], segment_index[19:10], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
    output logic         m_tuser    // index_error
);

    localparam int DIV_STAGES = tvg_pkg::ANGLE_BITS;
    localparam int CW         = tvg_pkg::COUNT_W;
    localparam int AB         = tvg_pkg::ANGLE_BITS;
    localparam int NS         = tvg_pkg::CORDIC_STEPS;

    // Configuration registers
    logic [tvg_pkg::RADIUS_W-1:0] centre_radius_reg;
    logic [tvg_pkg::RADIUS_W-1:0] tube_radius_reg;
    logic [CW-1:0]                segment_count_reg;
    logic [CW-1:0]                ring_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_radius_reg <= 16'd512;
            tube_radius_reg   <= 16'd256;
            segment_count_reg <= 11'd32;
            ring_count_reg    <= 11'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tvg_pkg::CFG_CENTRE_RADIUS: centre_radius_reg <= cfg_data;
                tvg_pkg::CFG_TUBE_RADIUS:   tube_radius_reg   <= cfg_data;
                tvg_pkg::CFG_SEGMENT_COUNT: segment_count_reg <= cfg_data[CW-1:0];
                tvg_pkg::CFG_RING_COUNT:    ring_count_reg    <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the resolutions
    logic [CW-1:0] ring_div;
    logic [CW-1:0] seg_div;

    assign ring_div = (ring_count_reg > CW'(tvg_pkg::MAX_RESOLUTION)) ?
                      CW'(tvg_pkg::MAX_RESOLUTION) : ring_count_reg;
    assign seg_div  = (segment_count_reg > CW'(tvg_pkg::MAX_RESOLUTION)) ?
                      CW'(tvg_pkg::MAX_RESOLUTION) : segment_count_reg;

    // Pipeline enable: stall only while the skid entry is full
    tvg_pkg::result_t skid_reg;
    tvg_pkg::result_t out_reg;
    tvg_pkg::result_t res_reg;
    logic             pipe_en;

    assign pipe_en  = !skid_reg.valid;
    assign s_tready = pipe_en;

    // Input word into the divider head
    logic [tvg_pkg::INDEX_W-1:0] ring_index;
    logic [tvg_pkg::INDEX_W-1:0] segment_index;
    tvg_pkg::div_stage_t         div_in;

    assign ring_index    = s_tdata[9:0];
    assign segment_index = s_tdata[19:10];

    always_comb
    begin
        div_in.valid    = s_tvalid;
        div_in.err      = ({1'b0, ring_index} >= ring_div) || ({1'b0, segment_index} >= seg_div);
        div_in.ring_rem = {1'b0, ring_index};
        div_in.ring_q   = '0;
        div_in.seg_rem  = {1'b0, segment_index};
        div_in.seg_q    = '0;
    end

    // Phase divider: one restoring step per stage for each angle
    tvg_pkg::div_stage_t div_reg  [DIV_STAGES+1];
    tvg_pkg::div_stage_t div_next [DIV_STAGES+1];

    assign div_next[0] = div_in;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic [CW:0] ring_t;
        logic [CW:0] seg_t;
        logic        ring_ge;
        logic        seg_ge;

        always_comb
        begin
            ring_t  = {div_reg[k].ring_rem, 1'b0};
            seg_t   = {div_reg[k].seg_rem, 1'b0};
            ring_ge = ring_t >= {1'b0, ring_div};
            seg_ge  = seg_t >= {1'b0, seg_div};
            div_next[k+1].valid    = div_reg[k].valid;
            div_next[k+1].err      = div_reg[k].err;
            div_next[k+1].ring_rem = ring_ge ? CW'(ring_t - {1'b0, ring_div}) : ring_t[CW-1:0];
            div_next[k+1].ring_q   = {div_reg[k].ring_q[AB-2:0], ring_ge};
            div_next[k+1].seg_rem  = seg_ge ? CW'(seg_t - {1'b0, seg_div}) : seg_t[CW-1:0];
            div_next[k+1].seg_q    = {div_reg[k].seg_q[AB-2:0], seg_ge};
        end
    end

    // Quarter-wave angle: scale the phase remainder by two pi
    logic [tvg_pkg::PROD_W-1:0] ring_prod;
    logic [tvg_pkg::PROD_W-1:0] seg_prod;
    tvg_pkg::cordic_stage_t     cord_reg  [NS+1];
    tvg_pkg::cordic_stage_t     cord_next [NS+1];

    always_comb
    begin
        ring_prod = tvg_pkg::PROD_W'(div_reg[DIV_STAGES].ring_q[tvg_pkg::REM_W-1:0])
                    * tvg_pkg::PROD_W'(tvg_pkg::TWO_PI_Q30);
        seg_prod  = tvg_pkg::PROD_W'(div_reg[DIV_STAGES].seg_q[tvg_pkg::REM_W-1:0])
                    * tvg_pkg::PROD_W'(tvg_pkg::TWO_PI_Q30);
        cord_next[0].valid     = div_reg[DIV_STAGES].valid;
        cord_next[0].err       = div_reg[DIV_STAGES].err;
        cord_next[0].ring.x    = tvg_pkg::CORDIC_GAIN_Q30;
        cord_next[0].ring.y    = '0;
        cord_next[0].ring.z    = $signed(tvg_pkg::Z_W'(ring_prod[tvg_pkg::PROD_W-1:AB]));
        cord_next[0].ring.quad = div_reg[DIV_STAGES].ring_q[AB-1:AB-2];
        cord_next[0].seg.x     = tvg_pkg::CORDIC_GAIN_Q30;
        cord_next[0].seg.y     = '0;
        cord_next[0].seg.z     = $signed(tvg_pkg::Z_W'(seg_prod[tvg_pkg::PROD_W-1:AB]));
        cord_next[0].seg.quad  = div_reg[DIV_STAGES].seg_q[AB-1:AB-2];
    end

    // CORDIC rotation: one micro-rotation per stage
    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        always_comb
        begin
            cord_next[i+1] = cord_reg[i];
            if (!cord_reg[i].ring.z[tvg_pkg::Z_W-1])
            begin
                cord_next[i+1].ring.x = cord_reg[i].ring.x - (cord_reg[i].ring.y >>> i);
                cord_next[i+1].ring.y = cord_reg[i].ring.y + (cord_reg[i].ring.x >>> i);
                cord_next[i+1].ring.z = cord_reg[i].ring.z - tvg_pkg::atan_q30(i);
            end
            else
            begin
                cord_next[i+1].ring.x = cord_reg[i].ring.x + (cord_reg[i].ring.y >>> i);
                cord_next[i+1].ring.y = cord_reg[i].ring.y - (cord_reg[i].ring.x >>> i);
                cord_next[i+1].ring.z = cord_reg[i].ring.z + tvg_pkg::atan_q30(i);
            end
            if (!cord_reg[i].seg.z[tvg_pkg::Z_W-1])
            begin
                cord_next[i+1].seg.x = cord_reg[i].seg.x - (cord_reg[i].seg.y >>> i);
                cord_next[i+1].seg.y = cord_reg[i].seg.y + (cord_reg[i].seg.x >>> i);
                cord_next[i+1].seg.z = cord_reg[i].seg.z - tvg_pkg::atan_q30(i);
            end
            else
            begin
                cord_next[i+1].seg.x = cord_reg[i].seg.x + (cord_reg[i].seg.y >>> i);
                cord_next[i+1].seg.y = cord_reg[i].seg.y - (cord_reg[i].seg.x >>> i);
                cord_next[i+1].seg.z = cord_reg[i].seg.z + tvg_pkg::atan_q30(i);
            end
        end
    end

    // Quadrant unfold
    tvg_pkg::trig_stage_t   trig_reg;
    tvg_pkg::trig_stage_t   trig_next;
    tvg_pkg::cordic_lane_t  fin_ring;
    tvg_pkg::cordic_lane_t  fin_seg;

    assign fin_ring = cord_reg[NS].ring;
    assign fin_seg  = cord_reg[NS].seg;

    always_comb
    begin
        trig_next.valid = cord_reg[NS].valid;
        trig_next.err   = cord_reg[NS].err;
        case (fin_ring.quad)
            2'd0:
            begin
                trig_next.cp = tvg_pkg::TRIG_W'(fin_ring.x);
                trig_next.sp = tvg_pkg::TRIG_W'(fin_ring.y);
            end
            2'd1:
            begin
                trig_next.cp = tvg_pkg::TRIG_W'(-fin_ring.y);
                trig_next.sp = tvg_pkg::TRIG_W'(fin_ring.x);
            end
            2'd2:
            begin
                trig_next.cp = tvg_pkg::TRIG_W'(-fin_ring.x);
                trig_next.sp = tvg_pkg::TRIG_W'(-fin_ring.y);
            end
            default:
            begin
                trig_next.cp = tvg_pkg::TRIG_W'(fin_ring.y);
                trig_next.sp = tvg_pkg::TRIG_W'(-fin_ring.x);
            end
        endcase
        case (fin_seg.quad)
            2'd0:
            begin
                trig_next.ct = tvg_pkg::TRIG_W'(fin_seg.x);
                trig_next.st = tvg_pkg::TRIG_W'(fin_seg.y);
            end
            2'd1:
            begin
                trig_next.ct = tvg_pkg::TRIG_W'(-fin_seg.y);
                trig_next.st = tvg_pkg::TRIG_W'(fin_seg.x);
            end
            2'd2:
            begin
                trig_next.ct = tvg_pkg::TRIG_W'(-fin_seg.x);
                trig_next.st = tvg_pkg::TRIG_W'(-fin_seg.y);
            end
            default:
            begin
                trig_next.ct = tvg_pkg::TRIG_W'(fin_seg.y);
                trig_next.st = tvg_pkg::TRIG_W'(-fin_seg.x);
            end
        endcase
    end

    // First products: ring radius, height, normal terms
    tvg_pkg::mul1_stage_t mul1_reg;
    tvg_pkg::mul1_stage_t mul1_next;
    logic signed [16:0]   tr_s;
    logic signed [47:0]   cr_s;
    logic signed [48:0]   tcp;
    logic signed [32:0]   sp_sum;
    logic signed [16:0]   sp_rnd;

    always_comb
    begin
        tr_s   = $signed({1'b0, tube_radius_reg});
        cr_s   = $signed({2'b00, centre_radius_reg, 30'b0});
        tcp    = tr_s * trig_reg.cp;
        sp_sum = 33'(trig_reg.sp) + 33'sd32768;
        sp_rnd = $signed(sp_sum[32:16]);
        mul1_next.valid  = trig_reg.valid;
        mul1_next.err    = trig_reg.err;
        mul1_next.ring38 = 49'(cr_s) - tcp;
        mul1_next.tp     = tr_s * trig_reg.sp;
        mul1_next.cpct   = trig_reg.cp * trig_reg.ct;
        mul1_next.cpst   = trig_reg.cp * trig_reg.st;
        mul1_next.ny     = tvg_pkg::clamp_unit(20'(sp_rnd));
        mul1_next.ct     = trig_reg.ct;
        mul1_next.st     = trig_reg.st;
    end

    // Round to Q16 and Q1.14
    tvg_pkg::mul2_stage_t mul2_reg;
    tvg_pkg::mul2_stage_t mul2_next;
    logic signed [48:0]   ring_sum;
    logic signed [48:0]   py_sum;
    logic signed [63:0]   nx_sum;
    logic signed [63:0]   nz_sum;

    always_comb
    begin
        ring_sum = mul1_reg.ring38 + (49'sd1 <<< 21);
        py_sum   = mul1_reg.tp + (49'sd1 <<< 21);
        nx_sum   = (64'sd0 - mul1_reg.cpct) + (64'sd1 <<< 45);
        nz_sum   = (64'sd0 - mul1_reg.cpst) + (64'sd1 <<< 45);
        mul2_next.valid  = mul1_reg.valid;
        mul2_next.err    = mul1_reg.err;
        mul2_next.ring16 = $signed(ring_sum[48:22]);
        mul2_next.ct     = mul1_reg.ct;
        mul2_next.st     = mul1_reg.st;
        mul2_next.py     = tvg_pkg::POS_W'($signed(py_sum[48:22]));
        mul2_next.nx     = tvg_pkg::clamp_unit(20'($signed(nx_sum[63:46])));
        mul2_next.ny     = mul1_reg.ny;
        mul2_next.nz     = tvg_pkg::clamp_unit(20'($signed(nz_sum[63:46])));
    end

    // Toroidal products
    tvg_pkg::mul3_stage_t mul3_reg;
    tvg_pkg::mul3_stage_t mul3_next;

    always_comb
    begin
        mul3_next.valid = mul2_reg.valid;
        mul3_next.err   = mul2_reg.err;
        mul3_next.pxp   = mul2_reg.ring16 * mul2_reg.ct;
        mul3_next.pzp   = mul2_reg.ring16 * mul2_reg.st;
        mul3_next.py    = mul2_reg.py;
        mul3_next.nx    = mul2_reg.nx;
        mul3_next.ny    = mul2_reg.ny;
        mul3_next.nz    = mul2_reg.nz;
    end

    // Final rounding, drop payload on an index error
    tvg_pkg::result_t   res_next;
    logic signed [58:0] px_sum;
    logic signed [58:0] pz_sum;

    always_comb
    begin
        px_sum = mul3_reg.pxp + (59'sd1 <<< 29);
        pz_sum = mul3_reg.pzp + (59'sd1 <<< 29);
        res_next.valid = mul3_reg.valid;
        res_next.err   = mul3_reg.err;
        res_next.px    = tvg_pkg::POS_W'($signed(px_sum[58:30]));
        res_next.py    = mul3_reg.py;
        res_next.pz    = tvg_pkg::POS_W'($signed(pz_sum[58:30]));
        res_next.nx    = mul3_reg.nx;
        res_next.ny    = mul3_reg.ny;
        res_next.nz    = mul3_reg.nz;
        if (mul3_reg.err)
        begin
            res_next.px = '0;
            res_next.py = '0;
            res_next.pz = '0;
            res_next.nx = '0;
            res_next.ny = '0;
            res_next.nz = '0;
        end
    end

    // Advance the whole pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
                div_reg[k] <= '0;
            for (int i = 0; i <= NS; i++)
                cord_reg[i] <= '0;
            trig_reg <= '0;
            mul1_reg <= '0;
            mul2_reg <= '0;
            mul3_reg <= '0;
            res_reg  <= '0;
        end
        else if (pipe_en)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
                div_reg[k] <= div_next[k];
            for (int i = 0; i <= NS; i++)
                cord_reg[i] <= cord_next[i];
            trig_reg <= trig_next;
            mul1_reg <= mul1_next;
            mul2_reg <= mul2_next;
            mul3_reg <= mul3_next;
            res_reg  <= res_next;
        end
    end

    // Output register with skid entry
    logic out_take;

    assign out_take = !out_reg.valid || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else if (out_take)
        begin
            if (skid_reg.valid)
            begin
                out_reg        <= skid_reg;
                skid_reg.valid <= 1'b0;
            end
            else
            begin
                out_reg <= res_reg;
            end
        end
        else if (res_reg.valid && pipe_en)
        begin
            skid_reg <= res_reg;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tuser  = out_reg.err;
    assign m_tdata  = {out_reg.nz, out_reg.ny, out_reg.nx,
                       out_reg.pz, out_reg.py, out_reg.px};

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_reg.valid |-> out_reg.valid)
        else $error("skid word held while output register empty");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("index error word carries nonzero payload");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(res_reg))
        else $error("pipeline tail changed during stall");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(skid_reg.valid) |-> $past(m_tvalid && m_tready))
        else $error("skid word drained without an output transfer");
`endif

endmodule

/* verif/tb_top.sv */
module tb_top;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
        logic               err;
    } vertex_t;

    // CORDIC arctangents of 2^-i in Q30
    localparam longint ATAN_TBL [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127};

    // Holds the torus settings and the vertices still owed by the block
    class vertex_scoreboard;
        longint unsigned centre_r = 512, tube_r = 256, seg_cnt = 32, ring_cnt = 32;
        vertex_t pending[$];
        int errors = 0;

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                tvg_pkg::CFG_CENTRE_RADIUS: centre_r = 64'(val);
                tvg_pkg::CFG_TUBE_RADIUS:   tube_r = 64'(val);
                tvg_pkg::CFG_SEGMENT_COUNT: seg_cnt = 64'(val[10:0]);
                default:                    ring_cnt = 64'(val[10:0]);
            endcase
        endfunction

        function longint asr(longint v, int n);
            return v >>> n;
        endfunction

        function longint rnd(longint v, int n);
            return (v + (64'sd1 <<< (n - 1))) >>> n;
        endfunction

        function longint unit(longint v);
            return v > 16384 ? 16384 : (v < -16384 ? -16384 : v);
        endfunction

        function void sincos(longint unsigned ph, output longint c, output longint s);
            longint x, y, z, dx, dy;
            longint unsigned rem;
            logic [1:0] q;
            q = ph[15:14];
            rem = ph & 16'h3FFF;
            z = longint'((rem * 64'd6746518852) >> 16);
            x = 652032874;
            y = 0;
            for (int i = 0; i < 24; i++)
            begin
                dx = asr(y, i);
                dy = asr(x, i);
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= ATAN_TBL[i];
                end
                else
                begin
                    x += dx; y -= dy; z += ATAN_TBL[i];
                end
            end
            case (q)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        // Work out the vertex for one accepted index pair
        function void note_word(logic [9:0] ri, logic [9:0] si);
            vertex_t v;
            longint unsigned rc, sc;
            longint cp, sp, ct, st, r38, r16;
            rc = ring_cnt > 1024 ? 1024 : ring_cnt;
            sc = seg_cnt > 1024 ? 1024 : seg_cnt;
            v = '{default: 0};
            if (ri >= rc || si >= sc)
                v.err = 1'b1;
            else
            begin
                sincos((longint'(ri) << 16) / rc, cp, sp);
                sincos((longint'(si) << 16) / sc, ct, st);
                r38 = (longint'(centre_r) <<< 30) - longint'(tube_r) * cp;
                r16 = rnd(r38, 22);
                v.px = 32'(rnd(r16 * ct, 30));
                v.pz = 32'(rnd(r16 * st, 30));
                v.py = 32'(rnd(longint'(tube_r) * sp, 22));
                v.nx = 16'(unit(rnd(-(cp * ct), 46)));
                v.ny = 16'(unit(rnd(sp, 16)));
                v.nz = 16'(unit(rnd(-(cp * st), 46)));
            end
            pending.push_back(v);
        endfunction

        function void check_word(logic [143:0] d, logic e);
            vertex_t x;
            bit bad;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word %h", d);
                return;
            end
            x = pending.pop_front();
            bad = d[31:0] !== x.px || d[63:32] !== x.py || d[95:64] !== x.pz ||
                  d[111:96] !== x.nx || d[127:112] !== x.ny || d[143:128] !== x.nz ||
                  e !== x.err;
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %h %h %h %h %h %h %b got %h %b",
                             x.px, x.py, x.pz, x.nx, x.ny, x.nz, x.err, d, e);
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic cfg_we = 0;
    logic [1:0] cfg_addr = tvg_pkg::CFG_CENTRE_RADIUS;
    logic [15:0] cfg_data = 0;
    logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0, m_tuser;
    logic [23:0] s_tdata = 0;
    logic [143:0] m_tdata;
    vertex_scoreboard sb = new();
    bit hold_req = 0;
    int idle_cycles = 0;

    torus_vertex_generator dut (.*);

    always #5 clk = ~clk;

    // Check results and count idle cycles for the watchdog
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_word(s_tdata[9:0], s_tdata[19:10]);
        if (m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 5000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random wait per word, one long hold-off on request
    initial
    begin
        int w;
        bit held;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            w = $urandom_range(0, 9);
            if (hold_req && !held)
            begin
                held = 1;
                w = 150;
            end
            if (w != 0)
            begin
                m_tready <= 0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        s_tvalid <= 0;
        @(posedge clk);
        cfg_we <= 1; cfg_addr <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_word(logic [9:0] ri, logic [9:0] si, bit gaps);
        int g;
        g = gaps ? $urandom_range(0, 9) : 0;
        if (g != 0)
        begin
            s_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {4'd0, si, ri};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic random_phase(int n, bit allow_gaps);
        bit gaps;
        gaps = allow_gaps ? 1'($urandom_range(0, 1)) : 1'b0;
        for (int i = 0; i < n; i++)
            send_word(10'($urandom_range(0, 1023) % (sb.ring_cnt + 2)),
                      10'($urandom_range(0, 1023) % (sb.seg_cnt + 2)), gaps);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        // Directed: default settings, corners, out-of-range indexes, then full-scale, zero and one counts
        send_word(10'd0, 10'd0, 1'b0);
        send_word(10'd8, 10'd0, 1'b0);
        send_word(10'd16, 10'd8, 1'b0);
        send_word(10'd24, 10'd24, 1'b0);
        send_word(10'd31, 10'd31, 1'b0);
        send_word(10'd32, 10'd0, 1'b0);
        send_word(10'd0, 10'd32, 1'b0);
        send_word(10'd1023, 10'd1023, 1'b0);
        drain();
        write_reg(tvg_pkg::CFG_CENTRE_RADIUS, 16'hFFFF);
        write_reg(tvg_pkg::CFG_TUBE_RADIUS, 16'hFFFF);
        write_reg(tvg_pkg::CFG_SEGMENT_COUNT, 16'd1024);
        write_reg(tvg_pkg::CFG_RING_COUNT, 16'd1024);
        send_word(10'd1023, 10'd1023, 1'b0);
        send_word(10'd512, 10'd256, 1'b0);
        send_word(10'd341, 10'd682, 1'b0);
        send_word(10'h2AA, 10'h155, 1'b0);
        drain();
        write_reg(tvg_pkg::CFG_SEGMENT_COUNT, 16'h7FF);
        write_reg(tvg_pkg::CFG_RING_COUNT, 16'd0);
        send_word(10'd0, 10'd0, 1'b0);
        drain();
        write_reg(tvg_pkg::CFG_RING_COUNT, 16'd1);
        write_reg(tvg_pkg::CFG_CENTRE_RADIUS, 16'd0);
        write_reg(tvg_pkg::CFG_TUBE_RADIUS, 16'd0);
        send_word(10'd0, 10'd1023, 1'b0);
        send_word(10'd1, 10'd5, 1'b0);
        drain();
        // Random phases over several settings; block fills while receiver holds off
        write_reg(tvg_pkg::CFG_CENTRE_RADIUS, 16'($urandom));
        write_reg(tvg_pkg::CFG_TUBE_RADIUS, 16'($urandom));
        write_reg(tvg_pkg::CFG_SEGMENT_COUNT, 16'd1024);
        write_reg(tvg_pkg::CFG_RING_COUNT, 16'd1024);
        hold_req = 1;
        random_phase(100, 1'b0);
        drain();
        for (int p = 0; p < 7; p++)
        begin
            write_reg(tvg_pkg::CFG_CENTRE_RADIUS, 16'($urandom));
            write_reg(tvg_pkg::CFG_TUBE_RADIUS, 16'($urandom));
            write_reg(tvg_pkg::CFG_SEGMENT_COUNT, 16'($urandom_range(1, 1100)));
            write_reg(tvg_pkg::CFG_RING_COUNT, 16'($urandom_range(1, 1100)));
            random_phase(50, 1'b1);
            drain();
        end
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
